FILE: design/rpf_pkg.sv
`timescale 1ns / 1ps

package rpf_pkg;

    localparam int MAX_GROUPS_DEF  = 64;
    localparam int COORD_WIDTH_DEF = 16;

    localparam int IN_COORD_W = 16;
    localparam int IDX_W      = 6;
    localparam int DELTA_W    = 17;
    localparam int DIST_W     = 33;
    localparam int RESULT_CAP = 63;
    localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_BASE   = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

endpackage

FILE: design/rpf_if.sv
`timescale 1ns / 1ps

interface rpf_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   func;
    logic                                   start_set;
    logic signed [rpf_pkg::IN_COORD_W-1:0]  group_col;
    logic signed [rpf_pkg::IN_COORD_W-1:0]  group_row;
    logic        [rpf_pkg::IDX_W-1:0]       query_index;

    modport source (output valid, func, start_set, group_col, group_row, query_index,
                    input ready);
    modport sink   (input valid, func, start_set, group_col, group_row, query_index,
                    output ready);
endinterface

interface rpf_out_if;
    logic                                valid;
    logic                                ready;
    logic        [rpf_pkg::IDX_W-1:0]    query_group;
    logic        [rpf_pkg::IDX_W-1:0]    other_group;
    logic signed [rpf_pkg::DELTA_W-1:0]  delta_col;
    logic signed [rpf_pkg::DELTA_W-1:0]  delta_row;
    logic                                found;
    logic                                last;

    modport source (output valid, query_group, other_group, delta_col, delta_row, found, last,
                    input ready);
    modport sink   (input valid, query_group, other_group, delta_col, delta_row, found, last,
                    output ready);
endinterface

interface rpf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rpf_pkg::DIST_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: design/rpf_ram.sv
`timescale 1ns / 1ps

module rpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/radius_pair_finder.sv
`timescale 1ns / 1ps
// Load beat: no result.
// Query of group i: ready is low until its last beat is pushed (straight via FINISH when i
// is not loaded); one distance test per cycle, while the output does not stall, through the
// shared delta / square / compare pipeline fed by the store's read port.
// Ready is high only between items; output stalls freeze the pipeline.
// Reset clears the group count, max_dist_sq and all handshake state; store contents persist.
module radius_pair_finder #(
    parameter int MAX_GROUPS  = rpf_pkg::MAX_GROUPS_DEF,
    parameter int COORD_WIDTH = rpf_pkg::COORD_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rpf_in_if.sink       i_in,
    rpf_out_if.source    o_out,
    rpf_cfg_if.sink      i_cfg
);

    localparam int AW   = $clog2(MAX_GROUPS);
    localparam int CNTW = $clog2(MAX_GROUPS + 1);
    localparam int CMPW = (CNTW > rpf_pkg::IDX_W) ? CNTW : rpf_pkg::IDX_W;
    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * DW;
    localparam int SW   = PW + 1;
    localparam int DCW  = (SW > rpf_pkg::DIST_W) ? SW : rpf_pkg::DIST_W;
    localparam int MW   = 2 * COORD_WIDTH;

    rpf_pkg::t_state r_state, n_state;

    logic [rpf_pkg::DIST_W-1:0]   r_max_dist;
    logic [CNTW-1:0]              r_count;
    logic [rpf_pkg::IDX_W-1:0]    r_qi;
    logic [CNTW-1:0]              r_j;
    logic [rpf_pkg::RES_CNT_W-1:0] r_nres;
    logic [MW-1:0]                r_base;

    logic                         r_v1, r_v2, r_v3;
    logic [AW-1:0]                r_j1, r_j2, r_j3;
    logic signed [DW-1:0]         r_dx, r_dy, r_dx3, r_dy3;
    logic [PW-1:0]                r_sqx, r_sqy;

    logic                               r_pend_v;
    logic [rpf_pkg::IDX_W-1:0]          r_pend_j;
    logic signed [rpf_pkg::DELTA_W-1:0] r_pend_dc, r_pend_dr;

    logic                               r_out_valid;
    logic [rpf_pkg::IDX_W-1:0]          r_out_qg, r_out_og;
    logic signed [rpf_pkg::DELTA_W-1:0] r_out_dc, r_out_dr;
    logic                               r_out_found, r_out_last;

    logic                  w_accept, w_load, w_query, w_qi_ok;
    logic                  w_adv, w_more, w_issue, w_pipe_busy, w_qual, w_push;
    logic                  w_we, w_re;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [MW-1:0]         w_wdata, w_rdata;
    logic signed [COORD_WIDTH-1:0] w_col_j, w_row_j, w_col_b, w_row_b;
    logic [SW-1:0]         w_sum;

    logic [rpf_pkg::IDX_W-1:0]          w_push_og;
    logic signed [rpf_pkg::DELTA_W-1:0] w_push_dc, w_push_dr;
    logic                               w_push_found, w_push_last;

    assign i_in.ready = (r_state == rpf_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_load   = w_accept && (i_in.func == rpf_pkg::FUNC_LOAD);
    assign w_query  = w_accept && (i_in.func == rpf_pkg::FUNC_QUERY);
    assign w_qi_ok  = CMPW'(i_in.query_index) < CMPW'(r_count);

    assign w_adv       = !r_out_valid || o_out.ready;
    assign w_more      = (r_j < r_count) && (r_nres < rpf_pkg::RES_CNT_W'(rpf_pkg::RESULT_CAP));
    assign w_issue     = (r_state == rpf_pkg::ST_WALK) && w_adv && w_more;
    assign w_pipe_busy = r_v1 || r_v2 || r_v3;

    // store port
    assign w_we    = w_load && (i_in.start_set || (r_count < CNTW'(MAX_GROUPS)));
    assign w_waddr = i_in.start_set ? '0 : r_count[AW-1:0];
    assign w_wdata = {COORD_WIDTH'(i_in.group_col), COORD_WIDTH'(i_in.group_row)};
    assign w_re    = w_issue || (w_query && w_qi_ok);
    assign w_raddr = w_issue ? r_j[AW-1:0] : AW'(i_in.query_index);

    rpf_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_GROUPS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_col_j = w_rdata[MW-1:COORD_WIDTH];
    assign w_row_j = w_rdata[COORD_WIDTH-1:0];
    assign w_col_b = r_base[MW-1:COORD_WIDTH];
    assign w_row_b = r_base[COORD_WIDTH-1:0];

    assign w_sum  = SW'(r_sqx) + SW'(r_sqy);
    assign w_qual = r_v3 && (DCW'(w_sum) <= DCW'(r_max_dist))
                    && (r_nres < rpf_pkg::RES_CNT_W'(rpf_pkg::RESULT_CAP));

    always_comb begin
        w_push       = 1'b0;
        w_push_og    = r_pend_j;
        w_push_dc    = r_pend_dc;
        w_push_dr    = r_pend_dr;
        w_push_found = 1'b1;
        w_push_last  = 1'b0;
        if (r_state == rpf_pkg::ST_WALK) begin
            w_push = w_adv && w_qual && r_pend_v;
        end else if (r_state == rpf_pkg::ST_FINISH) begin
            w_push      = w_adv;
            w_push_last = 1'b1;
            if (!r_pend_v) begin
                w_push_og    = '0;
                w_push_dc    = '0;
                w_push_dr    = '0;
                w_push_found = 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rpf_pkg::ST_IDLE: begin
                if (w_query) begin
                    n_state = w_qi_ok ? rpf_pkg::ST_BASE : rpf_pkg::ST_FINISH;
                end
            end
            rpf_pkg::ST_BASE: begin
                n_state = rpf_pkg::ST_WALK;
            end
            rpf_pkg::ST_WALK: begin
                if (!w_more && !w_pipe_busy) begin
                    n_state = rpf_pkg::ST_FINISH;
                end
            end
            rpf_pkg::ST_FINISH: begin
                if (w_adv) begin
                    n_state = rpf_pkg::ST_IDLE;
                end
            end
            default: n_state = rpf_pkg::ST_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpf_pkg::ST_IDLE;
            r_max_dist  <= '0;
            r_count     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_pend_v    <= 1'b0;
            r_nres      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_dist <= i_cfg.data;
            end
            if (w_load) begin
                if (i_in.start_set) begin
                    r_count <= CNTW'(1);
                end else if (r_count < CNTW'(MAX_GROUPS)) begin
                    r_count <= r_count + CNTW'(1);
                end
            end
            if (w_query) begin
                r_pend_v <= 1'b0;
                r_nres   <= '0;
            end else if (r_state == rpf_pkg::ST_WALK && w_adv && w_qual) begin
                r_pend_v <= 1'b1;
                r_nres   <= r_nres + rpf_pkg::RES_CNT_W'(1);
            end
            if (w_adv) begin
                r_v1 <= w_issue;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_qi <= i_in.query_index;
            r_j  <= CNTW'(i_in.query_index) + CNTW'(1);
        end else if (w_issue) begin
            r_j <= r_j + CNTW'(1);
        end
        if (r_state == rpf_pkg::ST_BASE) begin
            r_base <= w_rdata;
        end
        if (w_adv) begin
            r_j1  <= r_j[AW-1:0];
            r_j2  <= r_j1;
            r_dx  <= DW'(w_col_j) - DW'(w_col_b);
            r_dy  <= DW'(w_row_j) - DW'(w_row_b);
            r_j3  <= r_j2;
            r_dx3 <= r_dx;
            r_dy3 <= r_dy;
            r_sqx <= PW'(PW'(r_dx) * PW'(r_dx));
            r_sqy <= PW'(PW'(r_dy) * PW'(r_dy));
        end
        if (r_state == rpf_pkg::ST_WALK && w_adv && w_qual) begin
            r_pend_j  <= rpf_pkg::IDX_W'(r_j3);
            r_pend_dc <= rpf_pkg::DELTA_W'(r_dx3);
            r_pend_dr <= rpf_pkg::DELTA_W'(r_dy3);
        end
        if (w_push) begin
            r_out_qg    <= r_qi;
            r_out_og    <= w_push_og;
            r_out_dc    <= w_push_dc;
            r_out_dr    <= w_push_dr;
            r_out_found <= w_push_found;
            r_out_last  <= w_push_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.query_group = r_out_qg;
    assign o_out.other_group = r_out_og;
    assign o_out.delta_col   = r_out_dc;
    assign o_out.delta_row   = r_out_dr;
    assign o_out.found       = r_out_found;
    assign o_out.last        = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_GROUPS))
        else $error("group count beyond store depth");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpf_pkg::ST_IDLE) |-> !(r_v1 || r_v2 || r_v3))
        else $error("distance pipeline busy while idle");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> o_out.last)
        else $error("empty beat not marked last");

    a_finish_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpf_pkg::ST_FINISH && w_adv) |=> (o_out.valid && o_out.last))
        else $error("query finished without a last beat");

    a_res_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= rpf_pkg::RES_CNT_W'(rpf_pkg::RESULT_CAP))
        else $error("result count beyond cap");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int     GROUPS        = rpf_pkg::MAX_GROUPS_DEF;
    localparam longint DIST_TOP      = 64'd8589672450;
    localparam int     SETTLE_CYCLES = GROUPS + 8;
    localparam int     IDLE_PCT      = 31;
    localparam int     RANDOM_ITEMS  = 110;

    typedef struct packed {
        logic                                  func;
        logic                                  start_set;
        logic signed [rpf_pkg::IN_COORD_W-1:0] col;
        logic signed [rpf_pkg::IN_COORD_W-1:0] row;
        logic        [rpf_pkg::IDX_W-1:0]      qidx;
    } t_group_item;

    typedef struct packed {
        logic        [rpf_pkg::IDX_W-1:0]   query_group;
        logic        [rpf_pkg::IDX_W-1:0]   other_group;
        logic signed [rpf_pkg::DELTA_W-1:0] delta_col;
        logic signed [rpf_pkg::DELTA_W-1:0] delta_row;
        logic                               found;
        logic                               last;
    } t_pair_res;

    logic i_clk;
    logic i_rst_n;

    rpf_in_if  in_bus ();
    rpf_out_if out_bus ();
    rpf_cfg_if cfg_bus ();

    radius_pair_finder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // shadow of the group store and distance register
    logic signed [rpf_pkg::IN_COORD_W-1:0] pos_col [GROUPS];
    logic signed [rpf_pkg::IN_COORD_W-1:0] pos_row [GROUPS];
    int        stored_groups = 0;
    longint    radius_sq     = 0;
    t_pair_res pairs_due [$];
    int        mismatches    = 0;
    bit        steady        = 1'b0;
    int        hold_off_len  = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic predict_pairs(input t_group_item it);
        t_pair_res pend;
        bit        have_pend;
        longint    dc, dr, ac, ar;
        int        n;
        have_pend = 1'b0;
        n = 0;
        if (it.func == rpf_pkg::FUNC_LOAD) begin
            if (it.start_set)
                stored_groups = 0;
            if (stored_groups < GROUPS) begin
                pos_col[stored_groups] = it.col;
                pos_row[stored_groups] = it.row;
                stored_groups++;
            end
            return;
        end
        if (int'(it.qidx) < stored_groups) begin
            for (int j = int'(it.qidx) + 1; j < stored_groups && n < rpf_pkg::RESULT_CAP;
                 j++) begin
                dc = longint'(pos_col[j]) - longint'(pos_col[it.qidx]);
                dr = longint'(pos_row[j]) - longint'(pos_row[it.qidx]);
                ac = (dc < 0) ? -dc : dc;
                ar = (dr < 0) ? -dr : dr;
                if (ac * ac + ar * ar <= radius_sq) begin
                    if (have_pend)
                        pairs_due.insert(pairs_due.size(), pend);
                    pend.query_group = it.qidx;
                    pend.other_group = rpf_pkg::IDX_W'(j);
                    pend.delta_col   = rpf_pkg::DELTA_W'(dc);
                    pend.delta_row   = rpf_pkg::DELTA_W'(dr);
                    pend.found       = 1'b1;
                    pend.last        = 1'b0;
                    have_pend = 1'b1;
                    n++;
                end
            end
        end
        if (have_pend) begin
            pend.last = 1'b1;
        end else begin
            pend.query_group = it.qidx;
            pend.other_group = '0;
            pend.delta_col   = '0;
            pend.delta_row   = '0;
            pend.found       = 1'b0;
            pend.last        = 1'b1;
        end
        pairs_due.insert(pairs_due.size(), pend);
    endtask

    task automatic send_group_item(input t_group_item it);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.func        <= it.func;
        in_bus.start_set   <= it.start_set;
        in_bus.group_col   <= it.col;
        in_bus.group_row   <= it.row;
        in_bus.query_index <= it.qidx;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        predict_pairs(it);
    endtask

    task automatic send_load(input bit start,
                             input logic signed [rpf_pkg::IN_COORD_W-1:0] col,
                             input logic signed [rpf_pkg::IN_COORD_W-1:0] row);
        send_group_item('{rpf_pkg::FUNC_LOAD, start, col, row, rpf_pkg::IDX_W'($urandom)});
    endtask

    task automatic send_query(input logic [rpf_pkg::IDX_W-1:0] idx);
        send_group_item('{rpf_pkg::FUNC_QUERY, 1'($urandom), rpf_pkg::IN_COORD_W'($urandom),
                          rpf_pkg::IN_COORD_W'($urandom), idx});
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        while (pairs_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radius(input longint v);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= rpf_pkg::DIST_W'(v);
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        radius_sq = v;
    endtask

    // result receiver; a requested hold-off keeps ready low, then clears itself
    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len > 0) begin
                out_bus.ready <= 1'b0;
                repeat (hold_off_len) @(posedge i_clk);
                hold_off_len = 0;
            end else begin
                out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        t_pair_res seen, want;
        if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            seen = '{out_bus.query_group, out_bus.other_group, out_bus.delta_col,
                     out_bus.delta_row, out_bus.found, out_bus.last};
            if (pairs_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: q=%0d j=%0d dc=%0d dr=%0d found=%0b last=%0b",
                             seen.query_group, seen.other_group, seen.delta_col,
                             seen.delta_row, seen.found, seen.last);
            end else begin
                want = pairs_due.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp: q=%0d j=%0d dc=%0d dr=%0d found=%0b last=%0b",
                                 want.query_group, want.other_group, want.delta_col,
                                 want.delta_row, want.found, want.last);
                        $display("         got: q=%0d j=%0d dc=%0d dr=%0d found=%0b last=%0b",
                                 seen.query_group, seen.other_group, seen.delta_col,
                                 seen.delta_row, seen.found, seen.last);
                    end
                end
            end
        end
    end

    task automatic test_empty_store();
        send_query(rpf_pkg::IDX_W'(0));
        send_query(rpf_pkg::IDX_W'(63));
        send_query(rpf_pkg::IDX_W'(1));
        wait_drained();
    endtask

    task automatic test_extremes();
        write_radius(DIST_TOP);
        send_load(1'b1, -16'sd32768, -16'sd32768);
        send_load(1'b0, 16'sd32767, 16'sd32767);
        send_load(1'b0, 16'sd0, 16'sd0);
        send_load(1'b0, -16'sd1, 16'sd1);
        send_load(1'b0, 16'sd32767, -16'sd32768);
        send_load(1'b0, 16'sd0, 16'sd0);
        send_query(rpf_pkg::IDX_W'(0));
        send_query(rpf_pkg::IDX_W'(2));
        send_query(rpf_pkg::IDX_W'(5));
        send_query(rpf_pkg::IDX_W'(6));
        send_query(rpf_pkg::IDX_W'(63));
        wait_drained();
        write_radius(DIST_TOP - 1);
        send_query(rpf_pkg::IDX_W'(0));
        wait_drained();
        // zero radius: only coincident groups pair up
        write_radius(0);
        send_query(rpf_pkg::IDX_W'(2));
        wait_drained();
        write_radius(1);
        send_query(rpf_pkg::IDX_W'(2));
        wait_drained();
        write_radius(2);
        send_query(rpf_pkg::IDX_W'(2));
        wait_drained();
    endtask

    task automatic test_output_stall();
        write_radius(DIST_TOP);
        send_load(1'b1, rpf_pkg::IN_COORD_W'($urandom), rpf_pkg::IN_COORD_W'($urandom));
        repeat (7) send_load(1'b0, rpf_pkg::IN_COORD_W'($urandom),
                             rpf_pkg::IN_COORD_W'($urandom));
        hold_off_len = 400;
        for (int q = 0; q < 6; q++)
            send_query(rpf_pkg::IDX_W'(q));
        wait_drained();
    endtask

    task automatic run_random_set(input int phase, inout int done_items);
        int          size, extra, spread, nq, c_col, c_row, pick;
        longint      r;
        logic [63:0] raw;
        t_group_item it;
        pick  = $urandom_range(19);
        extra = 0;
        if (phase == 0 || pick == 0) begin
            size  = GROUPS;
            extra = $urandom_range(1, 3);
        end else if (phase == 3) begin
            size = $urandom_range(20, 28);
        end else if (pick < 4) begin
            size = $urandom_range(13, 40);
        end else begin
            size = $urandom_range(2, 12);
        end
        case ($urandom_range(3))
            0:       spread = 2;
            1:       spread = 40;
            2:       spread = 1500;
            default: spread = 32768;
        endcase
        pick = $urandom_range(9);
        if (phase == 0 || pick == 1)
            r = DIST_TOP;
        else if (pick == 0)
            r = 0;
        else if (pick == 2)
            r = longint'({$urandom_range(1, 0), $urandom}) % (DIST_TOP + 1);
        else begin
            r = $urandom_range(0, 2 * spread);
            r = r * r;
        end
        wait_drained();
        write_radius(r);
        steady = (phase == 3);
        c_col = $urandom_range(65535);
        c_row = $urandom_range(65535);
        for (int k = 0; k < size + extra; k++) begin
            if (k > 0 && $urandom_range(9) == 0) begin
                // stray item: any function, any field values
                raw = {$urandom, $urandom};
                it  = raw[$bits(t_group_item)-1:0];
            end else begin
                it.func      = rpf_pkg::FUNC_LOAD;
                it.start_set = (k == 0);
                it.col       = rpf_pkg::IN_COORD_W'(c_col
                                   + int'($urandom_range(0, 2 * spread)) - spread);
                it.row       = rpf_pkg::IN_COORD_W'(c_row
                                   + int'($urandom_range(0, 2 * spread)) - spread);
                it.qidx      = rpf_pkg::IDX_W'($urandom);
            end
            if (!(it.func == rpf_pkg::FUNC_LOAD && !it.start_set && stored_groups >= GROUPS))
                done_items++;
            send_group_item(it);
        end
        nq = $urandom_range(2, 6);
        for (int q = 0; q < nq; q++) begin
            if (phase == 0 && q == 0)
                send_query(rpf_pkg::IDX_W'(0));
            else if ($urandom_range(4) == 0)
                send_query(rpf_pkg::IDX_W'($urandom));
            else
                send_query(rpf_pkg::IDX_W'($urandom_range(0, size - 1)));
            done_items++;
        end
        steady = 1'b0;
    endtask

    task automatic test_random_sets();
        int done_items;
        int phase;
        done_items = 0;
        phase = 0;
        while (done_items < RANDOM_ITEMS || phase < 4) begin
            run_random_set(phase, done_items);
            phase++;
        end
    endtask

    initial begin
        in_bus.valid       <= 1'b0;
        in_bus.func        <= rpf_pkg::FUNC_LOAD;
        in_bus.start_set   <= 1'b0;
        in_bus.group_col   <= '0;
        in_bus.group_row   <= '0;
        in_bus.query_index <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.data       <= '0;
        i_rst_n            <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_extremes();
        test_output_stall();
        test_random_sets();
        wait_drained();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
